[rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// Shared codes and widths for the rational arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  localparam int RES_W = 33;
  localparam int OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_MUL  = 2'd0,
    OP_ADD  = 2'd1,
    OP_SIMP = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

endpackage

`default_nettype wire

[rtl/rar_gcd_stage.sv]
// ----------------------------------------------------------------------------
// rar_gcd_stage
// One registered step of the binary gcd on two non-negative magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_gcd_stage #(
  parameter int MW = 15,
  parameter int KW = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW-1:0] u,
  input  wire logic [MW-1:0] v,
  input  wire logic [KW-1:0] k,
  output logic      [MW-1:0] u_q,
  output logic      [MW-1:0] v_q,
  output logic      [KW-1:0] k_q
);

  logic [MW-1:0] u_next;
  logic [MW-1:0] v_next;
  logic [KW-1:0] k_next;
  logic [MW-1:0] d_uv;
  logic [MW-1:0] d_vu;

  assign d_uv = u - v;
  assign d_vu = v - u;

  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    if (u == '0 || v == '0) begin
      u_next = u;
    end else if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + KW'(1);
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u >= v) begin
      u_next = d_uv >> 1;
    end else begin
      v_next = d_vu >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= u_next;
      v_q <= v_next;
      k_q <= k_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rar_div_stage.sv]
// ----------------------------------------------------------------------------
// rar_div_stage
// One registered restoring-division bit for numerator and denominator
// sharing a common divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_div_stage #(
  parameter int MW = 15
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW-1:0] g,
  input  wire logic [MW-1:0] qn,
  input  wire logic [MW:0]   rn,
  input  wire logic [MW-1:0] qd,
  input  wire logic [MW:0]   rd,
  output logic      [MW-1:0] qn_q,
  output logic      [MW:0]   rn_q,
  output logic      [MW-1:0] qd_q,
  output logic      [MW:0]   rd_q
);

  logic [MW:0]   sn;
  logic [MW:0]   sd;
  logic [MW:0]   gx;
  logic          tn;
  logic          td;

  assign gx = {1'b0, g};
  assign sn = {rn[MW-1:0], qn[MW-1]};
  assign sd = {rd[MW-1:0], qd[MW-1]};
  assign tn = (sn >= gx);
  assign td = (sd >= gx);

  always_ff @(posedge clk) begin
    if (en) begin
      rn_q <= tn ? sn - gx : sn;
      rd_q <= td ? sd - gx : sd;
      qn_q <= {qn[MW-2:0], tn};
      qd_q <= {qd[MW-2:0], td};
    end
  end

endmodule

`default_nettype wire

[rtl/rational_arith_reduce.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Fraction multiply, add, and gcd reduction in one fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel | signals                                   | flow
//  in      | in_valid, in_stall, operation, a/b num/den | item in
//  out     | out_valid, out_stall, res_num, res_den     | item out
//
//  One item enters per cycle unless in_stall is high; gcd steps and
//  quotient bits each own a stage.
//  Whole pipe holds while out_valid and out_stall are both high.
//  Reset clears the valid bits only.
`default_nettype none

module rational_arith_reduce #(
  parameter int OPERAND_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     operation,
  input  wire logic signed [OPERAND_BITS-1:0] a_num,
  input  wire logic signed [OPERAND_BITS-1:0] a_den,
  input  wire logic signed [OPERAND_BITS-1:0] b_num,
  input  wire logic signed [OPERAND_BITS-1:0] b_den,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [32:0]                  res_num,
  output logic signed [32:0]                  res_den
);
  import rar_pkg::*;

  localparam int N  = OPERAND_BITS;
  localparam int MW = N - 1;
  localparam int KW = $clog2(MW + 1);
  localparam int GS = 2 * MW;
  localparam int DS = MW;
  localparam int PW = 2 * N + 1;
  localparam int EW = (PW > RES_W) ? PW : RES_W;
  localparam int CS = GS + DS;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: input register
  logic                v0;
  op_t                 op0;
  logic signed [N-1:0] an0, ad0, bn0, bd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= op_t'(operation);
      an0 <= a_num;
      ad0 <= a_den;
      bn0 <= b_num;
      bd0 <= b_den;
    end
  end

  // stage 1: products
  logic                  v1;
  op_t                   op1;
  logic signed [N-1:0]   an1, ad1;
  logic signed [2*N-1:0] pa1, pb1, pd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op0;
      an1 <= an0;
      ad1 <= ad0;
      pa1 <= an0 * ((op0 == OP_ADD) ? bd0 : bn0);
      pb1 <= ad0 * bn0;
      pd1 <= ad0 * bd0;
    end
  end

  // stage 2: result select and gcd setup
  logic signed [PW-1:0]    sum1;
  logic signed [EW-1:0]    ext_a, ext_s, ext_d, ext_n, ext_m;
  logic signed [RES_W-1:0] rn_next, rd_next;
  logic                    simp_next;

  assign sum1  = PW'(pa1) + PW'(pb1);
  assign ext_a = EW'(pa1);
  assign ext_s = EW'(sum1);
  assign ext_d = EW'(pd1);
  assign ext_n = EW'(an1);
  assign ext_m = EW'(ad1);
  assign simp_next = (op1 == OP_SIMP) && (an1 >= 2) && (ad1 >= 2);

  always_comb begin
    case (op1)
      OP_MUL: begin
        rn_next = ext_a[RES_W-1:0];
        rd_next = ext_d[RES_W-1:0];
      end
      OP_ADD: begin
        rn_next = ext_s[RES_W-1:0];
        rd_next = ext_d[RES_W-1:0];
      end
      default: begin
        rn_next = ext_n[RES_W-1:0];
        rd_next = ext_m[RES_W-1:0];
      end
    endcase
  end

  logic                    cv   [CS+1];
  logic                    cs   [CS+1];
  logic signed [RES_W-1:0] crn  [CS+1];
  logic signed [RES_W-1:0] crd  [CS+1];
  logic [MW-1:0]           can  [GS+1];
  logic [MW-1:0]           cad  [GS+1];
  logic [MW-1:0]           gu   [GS+1];
  logic [MW-1:0]           gv   [GS+1];
  logic [KW-1:0]           gk   [GS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0]  <= simp_next;
      crn[0] <= rn_next;
      crd[0] <= rd_next;
      can[0] <= an1[MW-1:0];
      cad[0] <= ad1[MW-1:0];
      gu[0]  <= an1[MW-1:0];
      gv[0]  <= ad1[MW-1:0];
      gk[0]  <= '0;
    end
  end

  // carried payload for every gcd and divide stage
  for (genvar i = 0; i < CS; i++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1]  <= cs[i];
        crn[i+1] <= crn[i];
        crd[i+1] <= crd[i];
      end
    end
  end

  for (genvar i = 0; i < GS; i++) begin : g_gcd
    always_ff @(posedge clk) begin
      if (en) begin
        can[i+1] <= can[i];
        cad[i+1] <= cad[i];
      end
    end
    rar_gcd_stage #(.MW(MW), .KW(KW)) u_step (
      .clk (clk),
      .en  (en),
      .u   (gu[i]),
      .v   (gv[i]),
      .k   (gk[i]),
      .u_q (gu[i+1]),
      .v_q (gv[i+1]),
      .k_q (gk[i+1])
    );
  end

  logic [MW-1:0] gval;
  assign gval = (gu[GS] | gv[GS]) << gk[GS];

  logic [MW-1:0] dg [DS+1];
  logic [MW-1:0] qn [DS+1];
  logic [MW-1:0] qd [DS+1];
  logic [MW:0]   rn [DS+1];
  logic [MW:0]   rd [DS+1];

  assign dg[0] = gval;
  assign qn[0] = can[GS];
  assign qd[0] = cad[GS];
  assign rn[0] = '0;
  assign rd[0] = '0;

  for (genvar i = 0; i < DS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dg[i+1] <= dg[i];
      end
    end
    rar_div_stage #(.MW(MW)) u_bit (
      .clk  (clk),
      .en   (en),
      .g    (dg[i]),
      .qn   (qn[i]),
      .rn   (rn[i]),
      .qd   (qd[i]),
      .rd   (rd[i]),
      .qn_q (qn[i+1]),
      .rn_q (rn[i+1]),
      .qd_q (qd[i+1]),
      .rd_q (rd[i+1])
    );
  end

  assign out_valid = cv[CS];
  assign res_num   = cs[CS] ? RES_W'({1'b0, qn[DS]}) : crn[CS];
  assign res_den   = cs[CS] ? RES_W'({1'b0, qd[DS]}) : crd[CS];

  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall disagrees with output hold");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cv[GS] && cs[GS]) |-> (gval != '0))
    else $error("zero gcd on a reduce item");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

[dv/tb_rational_arith_reduce.sv]
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce
// Drives random and corner-case fraction items through the rational unit
// and checks every result against a behavioral fraction calculator.
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce;
  timeunit 1ns;
  timeprecision 1ps;
  import rar_pkg::*;

  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = OP_MUL;
  logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [32:0] res_num, res_den;

  logic [65:0] frac_q[$];
  int errors = 0;
  int idle_pct = 35;
  int hold_cycles = 0;
  int quiet = 0;

  always #6 clk = ~clk;

  rational_arith_reduce i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .a_num(a_num), .a_den(a_den), .b_num(b_num),
    .b_den(b_den), .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den)
  );

  function automatic logic [65:0] calc_fraction(logic [1:0] op, logic signed [15:0] an,
      logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
    longint n, d, x, y, r;
    n = an;
    d = ad;
    if (op == OP_MUL) begin
      n = longint'(an) * bn;
      d = longint'(ad) * bd;
    end else if (op == OP_ADD) begin
      n = longint'(an) * bd + longint'(ad) * bn;
      d = longint'(ad) * bd;
    end else if (op == OP_SIMP && an >= 2 && ad >= 2) begin
      x = an;
      y = ad;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      if (x >= 2) begin
        n = an / x;
        d = ad / x;
      end
    end
    return {n[32:0], d[32:0]};
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
      logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    frac_q.push_back(calc_fraction(op, an, ad, bn, bd));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(3)) - 16'd1;
      3: return 16'($urandom_range(60));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0002};
    for (int i = 0; i < 6; i++) begin
      send_item(OP_MUL, ext[i], ext[5 - i], ext[i], ext[(i + 2) % 6]);
      send_item(OP_ADD, ext[i], ext[(i + 1) % 6], ext[5 - i], ext[i]);
    end
    send_item(OP_SIMP, 16'd12, 16'd18, 16'h0, 16'h0);
    send_item(OP_SIMP, 16'd7, 16'd9, 16'hffff, 16'hffff);
    send_item(OP_SIMP, 16'd1, 16'd10, 16'h0, 16'h0);
    send_item(OP_SIMP, 16'hfff4, 16'd8, 16'h0, 16'h0);
    send_item(OP_SIMP, 16'd0, 16'd8, 16'h0, 16'h0);
    send_item(OP_SIMP, 16'h7ffe, 16'h7ffe, 16'h0, 16'h0);
    send_item(OP_SIMP, 16'd8, 16'd0, 16'h0, 16'h0);
    send_item(OP_RSVD, 16'h8000, 16'h7fff, 16'h1234, 16'h5678);
    send_item(OP_MUL, 16'd3, 16'd0, 16'd5, 16'd7);
  endtask

  task automatic test_random(int count);
    logic [15:0] g;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        g = 16'($urandom_range(2, 90));
        send_item(OP_SIMP, g * 16'($urandom_range(1, 300)), g * 16'($urandom_range(1, 300)),
                  16'($urandom), 16'($urandom));
      end else begin
        send_item(2'($urandom_range(3)), rand_operand(), rand_operand(), rand_operand(),
                  rand_operand());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    test_random(100);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [65:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (frac_q.size() == 0) begin
        $display("%0t: unexpected item num=%0d den=%0d", $time, res_num, res_den);
        errors++;
      end else begin
        want = frac_q.pop_front();
        if (res_num !== want[65:33]) begin
          $display("%0t: res_num exp %0d got %0d", $time, $signed(want[65:33]), res_num);
          errors++;
        end
        if (res_den !== want[32:0]) begin
          $display("%0t: res_den exp %0d got %0d", $time, $signed(want[32:0]), res_den);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    idle_pct = 0;
    test_random(400);
    idle_pct = 35;
    test_random(720);
    in_valid <= 1'b0;
    while (frac_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/rar_pkg.sv
rtl/rar_gcd_stage.sv
rtl/rar_div_stage.sv
rtl/rational_arith_reduce.sv
dv/tb_rational_arith_reduce.sv
